// ----- src/cls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear solver package
// Shared widths, command and status structs for the solver core.
// ----------------------------------------------------------------------------
package cls_pkg;

  localparam int MAX_N = 4;
  localparam int IDX_W = 2;
  localparam int CNT_W = 5;
  localparam int DET_W = 80;
  localparam int NUM_W = 96;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DET_CLEAR,
    OP_DET_MAC,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [IDX_W-1:0]  col;
    logic [4:0]        perm;
    logic              use_rhs;
    logic [IDX_W-1:0]  n_m1;
    logic              is_last;
  } dp_cmd_t;

  typedef struct packed {
    logic det_zero;
  } dp_status_t;

endpackage

// ----- src/cls_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear solver datapath
// Coefficient store, permutation product accumulator and bit-serial divider.
// ----------------------------------------------------------------------------
module cls_datapath (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic                  wr_rhs,
  input  logic [3:0]            wr_addr,
  input  logic signed [15:0]    wr_data,
  input  cls_pkg::dp_cmd_t      cmd,
  output cls_pkg::dp_status_t   status,
  output logic                  out_valid,
  output logic [1:0]            out_unknown_index,
  output logic signed [31:0]    out_solution,
  output logic                  out_singular,
  output logic                  out_last
);
  import cls_pkg::*;

  logic signed [15:0] coef_r [MAX_N*MAX_N];
  logic signed [15:0] rhs_r  [MAX_N];
  logic signed [DET_W-1:0] acc_r, det_r;
  logic [DET_W-1:0] dabs_r;
  logic dneg_r, qneg_r;
  logic [NUM_W-1:0] num_r, quo_r;
  logic [DET_W:0] rem_r;
  logic par_r;

  // Permutation rank decoded into a column per row (Lehmer code over n).
  logic [IDX_W-1:0] pc [MAX_N];
  logic             par;
  logic signed [15:0] e [MAX_N];
  logic signed [31:0] p01, p23;
  logic signed [63:0] prod;
  logic [DET_W:0] rsh;
  logic [DET_W-1:0] ni_abs;

  always_comb begin
    logic [3:0] used;
    logic [4:0] rk;
    logic [1:0] d [MAX_N];
    logic [1:0] k;
    logic       found;
    used = '0;
    rk = cmd.perm;
    // Mixed-radix digits of the rank with weights 6, 2 and 1.
    if (rk >= 5'd18) begin
      d[0] = 2'd3; rk = rk - 5'd18;
    end else if (rk >= 5'd12) begin
      d[0] = 2'd2; rk = rk - 5'd12;
    end else if (rk >= 5'd6) begin
      d[0] = 2'd1; rk = rk - 5'd6;
    end else d[0] = 2'd0;
    if (rk >= 5'd4) begin
      d[1] = 2'd2; rk = rk - 5'd4;
    end else if (rk >= 5'd2) begin
      d[1] = 2'd1; rk = rk - 5'd2;
    end else d[1] = 2'd0;
    d[2] = rk[1:0];
    d[3] = 2'd0;
    par = 1'b0;
    for (int r = 0; r < MAX_N; r++) begin
      // Row r of an n by n matrix takes the digit of weight (n-1-r)!.
      k = 2'd0;
      if (r <= int'(cmd.n_m1)) k = d[2'(r + MAX_N - 1 - int'(cmd.n_m1))];
      pc[r] = '0;
      found = 1'b0;
      for (int c = 0; c < MAX_N; c++) begin
        if (!used[c] && !found) begin
          if (k == 2'd0) begin
            pc[r] = IDX_W'(c);
            found = 1'b1;
          end else k = k - 2'd1;
        end
      end
      par = par ^ d[r][0];
      if (r <= int'(cmd.n_m1)) used[pc[r]] = 1'b1;
    end
  end

  always_comb begin
    for (int r = 0; r < MAX_N; r++) begin
      if (r > int'(cmd.n_m1)) e[r] = 16'sd1;
      else if (cmd.use_rhs && pc[r] == cmd.col) e[r] = rhs_r[r];
      else e[r] = coef_r[{2'(r), pc[r]}];
    end
  end

  assign prod   = p01 * p23;
  assign ni_abs = acc_r[DET_W-1] ? DET_W'(-acc_r) : DET_W'(acc_r);
  assign rsh    = {rem_r[DET_W-1:0], num_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_rhs) rhs_r[wr_addr[IDX_W-1:0]] <= wr_data;
      else coef_r[wr_addr] <= wr_data;
    end
    p01 <= e[0] * e[1];
    p23 <= e[2] * e[3];
    par_r <= par;
    out_valid <= 1'b0;
    case (cmd.op)
      OP_DET_CLEAR: begin
        if (cmd.use_rhs == 1'b0 && cmd.col == '0 && cmd.is_last) begin
          det_r  <= acc_r;
          dabs_r <= acc_r[DET_W-1] ? DET_W'(-acc_r) : DET_W'(acc_r);
          dneg_r <= acc_r[DET_W-1];
        end
        acc_r <= '0;
      end
      OP_DET_MAC: begin
        // The first cycle of a sum has no product ready yet and clears the sum.
        if (cmd.is_last)
          acc_r <= par_r ? acc_r - DET_W'(prod) : acc_r + DET_W'(prod);
        else acc_r <= '0;
      end
      OP_DIV_INIT: begin
        num_r  <= {ni_abs, 16'd0};
        qneg_r <= acc_r[DET_W-1] ^ dneg_r;
        rem_r  <= '0;
        quo_r  <= '0;
      end
      OP_DIV_STEP: begin
        num_r <= num_r << 1;
        if (rsh >= {1'b0, dabs_r}) begin
          rem_r <= rsh - {1'b0, dabs_r};
          quo_r <= {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= rsh;
          quo_r <= {quo_r[NUM_W-2:0], 1'b0};
        end
      end
      OP_EMIT: begin
        out_valid         <= 1'b1;
        out_unknown_index <= cmd.col;
        out_last          <= cmd.is_last;
        out_singular      <= status.det_zero;
        if (status.det_zero) out_solution <= '0;
        else if (!qneg_r)
          out_solution <= (|quo_r[NUM_W-1:31]) ? 32'sh7FFFFFFF : 32'(quo_r);
        else
          out_solution <= (|quo_r[NUM_W-1:32] || (quo_r[31] && |quo_r[30:0]))
                          ? 32'sh80000000 : 32'(-quo_r[31:0]);
      end
      default: begin
      end
    endcase
  end

  assign status.det_zero = (det_r == '0);
endmodule

// ----- src/cls_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear solver controller
// Sequences loading, determinant sums, division and result emission.
// ----------------------------------------------------------------------------
module cls_controller (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [15:0]    in_value,
  output logic                  busy,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_matrix_size,
  output logic                  wr_en,
  output logic                  wr_rhs,
  output logic [3:0]            wr_addr,
  output logic signed [15:0]    wr_data,
  output cls_pkg::dp_cmd_t      cmd,
  input  cls_pkg::dp_status_t   status
);
  import cls_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD, S_MAC, S_FLUSH, S_CHK, S_TEST, S_DINIT, S_DSTEP, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] size_r;
  logic [CNT_W-1:0] cnt_r;
  logic [4:0] perm_r;
  logic [IDX_W-1:0] col_r;
  logic rhs_pass_r;
  logic [1:0] pipe_r;
  logic [6:0] dcnt_r;
  logic [IDX_W-1:0] nm1;
  logic [4:0] nfact_m1;
  logic [2:0] n;
  logic [CNT_W-1:0] nn, total;
  logic [1:0] rr, cc;
  logic accept;

  assign n = (size_r == 3'd0) ? 3'd1 : (size_r > 3'(MAX_N)) ? 3'(MAX_N) : size_r;
  assign nm1 = IDX_W'(n - 3'd1);
  assign nn = CNT_W'(n) * CNT_W'(n);
  assign total = nn + CNT_W'(n);
  always_comb begin
    case (n)
      3'd4: nfact_m1 = 5'd23;
      3'd3: nfact_m1 = 5'd5;
      3'd2: nfact_m1 = 5'd1;
      default: nfact_m1 = 5'd0;
    endcase
  end

  assign busy = (state_r != S_LOAD);
  assign cfg_ready = (state_r == S_LOAD);
  assign accept = start && !busy;

  always_comb begin
    rr = '0; cc = '0;
    for (int r = 0; r < MAX_N; r++)
      for (int c = 0; c < MAX_N; c++)
        if (CNT_W'(r) * CNT_W'(n) + CNT_W'(c) == cnt_r && r < 32'(n) && c < 32'(n)) begin
          rr = 2'(r); cc = 2'(c);
        end
  end
  assign wr_en   = accept;
  assign wr_rhs  = (cnt_r >= nn);
  assign wr_addr = wr_rhs ? 4'(cnt_r - nn) : {rr, cc};
  assign wr_data = in_value;

  // Permutations are enumerated by rank over n - 1 .. 0 with a fixed width
  // of MAX_N; ranks above (n! - 1) are never issued for smaller n.
  always_comb begin
    cmd = '0;
    cmd.col = col_r;
    cmd.use_rhs = rhs_pass_r;
    cmd.n_m1 = nm1;
    cmd.perm = perm_r;
    case (state_r)
      S_MAC:   begin cmd.op = OP_DET_MAC; cmd.is_last = (pipe_r == 2'd0); end
      S_FLUSH: begin cmd.op = OP_DET_MAC; cmd.is_last = 1'b1; end
      S_CHK:   begin
        // After the sum over A the determinant is kept for the divisions.
        if (!rhs_pass_r) begin
          cmd.op = OP_DET_CLEAR;
          cmd.is_last = 1'b1;
        end else cmd.op = OP_NONE;
      end
      S_DINIT: cmd.op = OP_DIV_INIT;
      S_DSTEP: cmd.op = OP_DIV_STEP;
      S_EMIT:  begin
        cmd.op = OP_EMIT;
        cmd.is_last = status.det_zero || (col_r == nm1);
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_comb state_nxt = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      size_r <= 3'd4;
      cnt_r <= '0;
      perm_r <= '0; col_r <= '0; rhs_pass_r <= 1'b0; pipe_r <= '0; dcnt_r <= '0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (cfg_valid) begin
            size_r <= cfg_matrix_size;
            cnt_r <= '0;
          end else if (accept) begin
            if (cnt_r + 1'b1 == total) begin
              cnt_r <= '0;
              state_r <= S_MAC;
              perm_r <= '0; col_r <= '0; rhs_pass_r <= 1'b0; pipe_r <= 2'd1;
            end else cnt_r <= cnt_r + 1'b1;
          end
        end
        S_MAC: begin
          pipe_r <= 2'd0;
          if (perm_r == nfact_m1) state_r <= S_FLUSH;
          else perm_r <= perm_r + 5'd1;
        end
        S_FLUSH: state_r <= S_CHK;
        S_CHK: begin
          if (!rhs_pass_r) state_r <= S_TEST;
          else state_r <= S_DINIT;
        end
        S_TEST: begin
          if (status.det_zero) state_r <= S_EMIT;
          else begin
            rhs_pass_r <= 1'b1; perm_r <= '0; pipe_r <= 2'd1; state_r <= S_MAC;
          end
        end
        S_DINIT: begin dcnt_r <= 7'(NUM_W - 1); state_r <= S_DSTEP; end
        S_DSTEP: begin
          if (dcnt_r == '0) state_r <= S_EMIT;
          else dcnt_r <= dcnt_r - 7'd1;
        end
        S_EMIT: begin
          if (status.det_zero || col_r == nm1) state_r <= S_LOAD;
          else begin
            col_r <= col_r + 1'b1; perm_r <= '0; pipe_r <= 2'd1; state_r <= S_MAC;
          end
        end
        default: state_r <= state_nxt;
      endcase
    end
  end
endmodule

// ----- src/cramer_linear_solver_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cramer linear solver core
// Solves A x = b for up to four unknowns from a stream of Q8.8 values.
// ----------------------------------------------------------------------------
// Usage: a request is accepted when start is high and busy is low; in_value
// carries n*n coefficients in row-major order, then n right-hand-side values.
// cfg_valid/cfg_ready writes matrix_size (0 acts as 1, above 4 acts as 4) and
// restarts the load; write it only while the block is idle.
// Loading takes one cycle per value. After the last value busy rises while
// det(A) is summed over all n! permutations, one product per cycle, then
// each det(A_i) the same way, each followed by a restoring divider over the
// 96-bit numerator. Result i is registered from S_EMIT after its division
// ends; the last one shows in the first idle cycle. A zero determinant ends
// the run after the sum over A with one result that has out_singular set.
// Each result is shown for one cycle with out_valid high; the receiver
// cannot stall. Reset sets matrix_size to 4 and clears the load counter;
// stores are not cleared.
// ----------------------------------------------------------------------------
module cramer_linear_solver_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_matrix_size,
  output logic               out_valid,
  output logic [1:0]         out_unknown_index,
  output logic signed [31:0] out_solution,
  output logic               out_singular,
  output logic               out_last
);
  import cls_pkg::*;

  dp_cmd_t cmd;
  dp_status_t status;
  logic wr_en, wr_rhs;
  logic [3:0] wr_addr;
  logic signed [15:0] wr_data;

  cls_controller u_ctrl (
    .clk, .rst_n, .start, .in_value, .busy, .cfg_valid, .cfg_ready,
    .cfg_matrix_size, .wr_en, .wr_rhs, .wr_addr, .wr_data, .cmd, .status
  );

  cls_datapath u_dp (
    .clk, .wr_en, .wr_rhs, .wr_addr, .wr_data, .cmd, .status,
    .out_valid, .out_unknown_index, .out_solution, .out_singular, .out_last
  );
endmodule

// ----- src/cls_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear solver checker
// Port-level properties of the solver core.
// ----------------------------------------------------------------------------
module cls_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic cfg_ready,
  input logic out_valid,
  input logic out_singular,
  input logic out_last,
  input logic signed [31:0] out_solution
);
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_solution == 0 && out_last)
    else $error("singular result not zero or not last");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !busy) else $error("config ready while busy");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !busy) else $error("busy after last result");
endmodule

bind cramer_linear_solver_core cls_checker u_chk (
  .clk, .rst_n, .busy, .cfg_ready, .out_valid, .out_singular, .out_last, .out_solution
);

// ----- tb/sv/tb_cramer_linear_solver_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cramer linear solver core testbench
// Streams coefficient and right-hand-side requests at several matrix sizes,
// predicts every solution with exact wide arithmetic and checks each result.
// ----------------------------------------------------------------------------
module tb_cramer_linear_solver_core;

  localparam int MAXN = cls_pkg::MAX_N;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 600;

  typedef struct packed {
    logic [1:0]         idx;
    logic signed [31:0] sol;
    logic               sing;
    logic               last;
  } solution_t;

  // A row either writes the size (low bits of value) or sends one value.
  typedef struct {
    logic               is_cfg;
    logic signed [15:0] value;
    logic               has_exp;
    solution_t          exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_value = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_matrix_size = '0;
  logic out_valid;
  logic [1:0] out_unknown_index;
  logic signed [31:0] out_solution;
  logic out_singular;
  logic out_last;

  cramer_linear_solver_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_value(in_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_matrix_size(cfg_matrix_size),
    .out_valid(out_valid), .out_unknown_index(out_unknown_index),
    .out_solution(out_solution), .out_singular(out_singular), .out_last(out_last)
  );

  // Predictor state.
  logic [2:0] size_reg;
  logic signed [15:0] coef_mem [MAXN*MAXN];
  logic signed [15:0] rhs_mem [MAXN];
  int unsigned loaded;

  solution_t expected_q[$];
  int errors = 0;
  int idle_pct = 0;
  int watchdog = 0;
  row_t dir_rows[$];

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int active_n();
    if (size_reg == 0) return 1;
    if (size_reg > MAXN) return MAXN;
    return int'(size_reg);
  endfunction

  // Exact determinant via permutation-free cofactor recursion over a column mask.
  function automatic logic signed [127:0] minor_det(
      input logic signed [15:0] m [MAXN][MAXN], input int n, input int row,
      input int mask);
    logic signed [127:0] acc;
    int k;
    acc = 0;
    k = 0;
    for (int c = 0; c < n; c++) begin
      if (mask[c]) begin
        if (row == n - 1) return 128'(m[row][c]);
        if (k[0]) acc -= minor_det(m, n, row + 1, mask & ~(1 << c)) * m[row][c];
        else acc += minor_det(m, n, row + 1, mask & ~(1 << c)) * m[row][c];
        k++;
      end
    end
    return acc;
  endfunction

  task automatic predict_load(input logic signed [15:0] v);
    int n;
    int unsigned nn;
    logic signed [15:0] m [MAXN][MAXN];
    logic signed [127:0] d, di;
    logic [127:0] dabs, nabs, q;
    logic neg;
    solution_t r;
    n = active_n();
    nn = n * n;
    if (loaded >= nn + n) loaded = 0;
    if (loaded < nn) coef_mem[(loaded / n) * MAXN + loaded % n] = v;
    else rhs_mem[loaded - nn] = v;
    loaded++;
    if (loaded < nn + n) return;
    loaded = 0;
    for (int i = 0; i < MAXN; i++)
      for (int j = 0; j < MAXN; j++) m[i][j] = coef_mem[i*MAXN + j];
    d = minor_det(m, n, 0, (1 << n) - 1);
    if (d == 0) begin
      r = '{idx: 2'd0, sol: 32'sd0, sing: 1'b1, last: 1'b1};
      expected_q.push_back(r);
      return;
    end
    dabs = d < 0 ? -d : d;
    for (int u = 0; u < n; u++) begin
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) m[i][j] = (j == u) ? rhs_mem[i] : coef_mem[i*MAXN + j];
      di = minor_det(m, n, 0, (1 << n) - 1);
      neg = (di < 0) ^ (d < 0);
      nabs = (di < 0) ? -di : di;
      q = (nabs << 16) / dabs;
      if (!neg) r.sol = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      else r.sol = (q > 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
      r.idx = u[1:0];
      r.sing = 1'b0;
      r.last = (u == n - 1);
      expected_q.push_back(r);
    end
  endtask

  // Result checking at every edge; results cannot be held off.
  always @(posedge clk) begin
    solution_t got, want;
    if (rst_n && out_valid) begin
      got = '{idx: out_unknown_index, sol: out_solution, sing: out_singular, last: out_last};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result idx=%0d sol=%h", got.idx, got.sol);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp idx=%0d sol=%h sing=%b last=%b",
                      " got idx=%0d sol=%h sing=%b last=%b"},
                     want.idx, want.sol, want.sing, want.last,
                     got.idx, got.sol, got.sing, got.last);
        end
      end
    end
  end

  // Watchdog over cycles without any accepted request or result.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Leaves start high after the accepting edge; the next call or settle drops it.
  task automatic send_value(input logic signed [15:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_load(v);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_size(input logic [2:0] s);
    cfg_valid <= 1'b1;
    cfg_matrix_size <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_reg = s;
    loaded = 0;
  endtask

  function automatic void add_row(input logic is_cfg, input logic signed [15:0] v,
                                  input logic has_exp, input solution_t x);
    row_t rw;
    rw.is_cfg = is_cfg;
    rw.value = v;
    rw.has_exp = has_exp;
    rw.exp = x;
    dir_rows.push_back(rw);
  endfunction

  function automatic logic signed [15:0] rand_value(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(1023)) - 512);
      default: return 16'(($urandom_range(15) - 8) << 8);
    endcase
  endfunction

  initial begin
    int rand_budget;
    int n;
    logic [2:0] sizes [6];
    solution_t none;
    solution_t sing_exp;
    none = '0;
    sing_exp = '{idx: 2'd0, sol: 32'sd0, sing: 1'b1, last: 1'b1};
    size_reg = 3'd4;
    loaded = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset size 4 with a singular all-zero matrix.
    for (int i = 0; i < 20; i++) add_row(1'b0, 16'sd0, i == 19, sing_exp);
    // Size 0 acts as 1: extremes of the input range.
    add_row(1'b1, 16'sd0, 1'b0, none);
    add_row(1'b0, 16'sh0001, 1'b0, none);
    add_row(1'b0, 16'sh7FFF, 1'b1, '{idx: 2'd0, sol: 32'sh7FFF_0000, sing: 1'b0, last: 1'b1});
    add_row(1'b0, 16'sh8000, 1'b0, none);
    add_row(1'b0, 16'sh7FFF, 1'b1, '{idx: 2'd0, sol: 32'shFFFF_0002, sing: 1'b0, last: 1'b1});
    add_row(1'b0, 16'sh7FFF, 1'b0, none);
    add_row(1'b0, 16'sh8000, 1'b0, none);
    add_row(1'b0, 16'sh0100, 1'b0, none);
    add_row(1'b0, 16'shFF00, 1'b1, '{idx: 2'd0, sol: 32'shFFFF_0000, sing: 1'b0, last: 1'b1});
    // Partial load dropped by a size write.
    add_row(1'b1, 16'sd2, 1'b0, none);
    add_row(1'b0, 16'sh1234, 1'b0, none);
    add_row(1'b0, 16'sh0200, 1'b0, none);
    add_row(1'b1, 16'sd7, 1'b0, none);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_size(dir_rows[i].value[2:0]);
      end else begin
        send_value(dir_rows[i].value);
        if (dir_rows[i].has_exp &&
            (expected_q.size() == 0 || expected_q[$] !== dir_rows[i].exp)) begin
          errors++;
          if (errors <= 10)
            $display("directed row %0d: exp sol=%h sing=%b", i,
                     dir_rows[i].exp.sol, dir_rows[i].exp.sing);
        end
      end
    end

    sizes = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd7, 3'd2};
    rand_budget = 440;
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      write_size(sizes[ph]);
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 66;
        2: idle_pct = 15;
        default: idle_pct = 0;
      endcase
      n = active_n();
      for (int k = 0; k < 80 && rand_budget > 0; k++) begin
        send_value(rand_value(($urandom_range(9) < 2) ? 0 :
                              ($urandom_range(1) ? 1 : 2)));
        rand_budget--;
      end
    end
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
